// ===== design/mcc_pkg.sv =====
// shared types, register indexes and triangle rom of the marching cubes cell unit
`default_nettype none
package mcc_pkg;

	localparam int GRID_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z    = 3'd6;

	typedef struct packed {
		logic [9:0]         cell_x;
		logic [9:0]         cell_y;
		logic [9:0]         cell_z;
		logic signed [31:0] corner_value_0;
		logic signed [31:0] corner_value_1;
		logic signed [31:0] corner_value_2;
		logic signed [31:0] corner_value_3;
		logic signed [31:0] corner_value_4;
		logic signed [31:0] corner_value_5;
		logic signed [31:0] corner_value_6;
		logic signed [31:0] corner_value_7;
	} mcc_cell_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic signed [31:0] third_x;
		logic signed [31:0] third_y;
		logic signed [31:0] third_z;
		logic               last_triangle;
	} mcc_tri_t;

	// corner offset as {z, y, x}
	function automatic logic [2:0] corner_off(input logic [2:0] c);
		logic [2:0] r;
		unique case (c)
			3'd0: r = 3'b000;
			3'd1: r = 3'b001;
			3'd2: r = 3'b011;
			3'd3: r = 3'b010;
			3'd4: r = 3'b100;
			3'd5: r = 3'b101;
			3'd6: r = 3'b111;
			3'd7: r = 3'b110;
		endcase
		return r;
	endfunction

	// edge end corners as {first, second}
	function automatic logic [5:0] edge_ends(input logic [3:0] e);
		logic [5:0] r;
		unique case (e)
			4'd0:    r = {3'd0, 3'd1};
			4'd1:    r = {3'd1, 3'd2};
			4'd2:    r = {3'd2, 3'd3};
			4'd3:    r = {3'd3, 3'd0};
			4'd4:    r = {3'd4, 3'd5};
			4'd5:    r = {3'd5, 3'd6};
			4'd6:    r = {3'd6, 3'd7};
			4'd7:    r = {3'd7, 3'd4};
			4'd8:    r = {3'd0, 3'd4};
			4'd9:    r = {3'd1, 3'd5};
			4'd10:   r = {3'd2, 3'd6};
			4'd11:   r = {3'd3, 3'd7};
			default: r = {3'd0, 3'd1};
		endcase
		return r;
	endfunction

	function automatic logic [2:0] ntri_of(input logic [3:0] len);
		logic [2:0] r;
		unique case (len)
			4'd0, 4'd1, 4'd2:    r = 3'd0;
			4'd3, 4'd4, 4'd5:    r = 3'd1;
			4'd6, 4'd7, 4'd8:    r = 3'd2;
			4'd9, 4'd10, 4'd11:  r = 3'd3;
			4'd12, 4'd13, 4'd14: r = 3'd4;
			default:             r = 3'd5;
		endcase
		return r;
	endfunction

	// digit count in the top nibble, edge digits right aligned, first digit leftmost
	function automatic logic [63:0] tri_rom(input logic [7:0] c);
		logic [63:0] t;
		unique case (c)
			8'd0:   t = {4'd0, 60'h0};
			8'd1:   t = {4'd3, 60'h083};
			8'd2:   t = {4'd3, 60'h019};
			8'd3:   t = {4'd6, 60'h183981};
			8'd4:   t = {4'd3, 60'h12a};
			8'd5:   t = {4'd6, 60'h08312a};
			8'd6:   t = {4'd6, 60'h92a029};
			8'd7:   t = {4'd10, 60'h2a8a982832};
			8'd8:   t = {4'd3, 60'h3b2};
			8'd9:   t = {4'd6, 60'h0b28b0};
			8'd10:  t = {4'd6, 60'h19023b};
			8'd11:  t = {4'd9, 60'h1b219b98b};
			8'd12:  t = {4'd6, 60'h3a1ba3};
			8'd13:  t = {4'd9, 60'h0a108a8ba};
			8'd14:  t = {4'd9, 60'h3903b9ba9};
			8'd15:  t = {4'd6, 60'h98aa8b};
			8'd16:  t = {4'd3, 60'h478};
			8'd17:  t = {4'd6, 60'h430734};
			8'd18:  t = {4'd6, 60'h019847};
			8'd19:  t = {4'd9, 60'h419471731};
			8'd20:  t = {4'd6, 60'h12a847};
			8'd21:  t = {4'd9, 60'h34730412a};
			8'd22:  t = {4'd9, 60'h92a902847};
			8'd23:  t = {4'd12, 60'h2a9297273794};
			8'd24:  t = {4'd6, 60'h8473b2};
			8'd25:  t = {4'd9, 60'hb47b24204};
			8'd26:  t = {4'd9, 60'h90184723b};
			8'd27:  t = {4'd12, 60'h47b94b9b2921};
			8'd28:  t = {4'd9, 60'h3a13ba784};
			8'd29:  t = {4'd12, 60'h1ba14b1047b4};
			8'd30:  t = {4'd12, 60'h47890b9bab03};
			8'd31:  t = {4'd9, 60'h47b4b99ba};
			8'd32:  t = {4'd3, 60'h954};
			8'd33:  t = {4'd6, 60'h954083};
			8'd34:  t = {4'd6, 60'h054150};
			8'd35:  t = {4'd9, 60'h854835315};
			8'd36:  t = {4'd6, 60'h12a954};
			8'd37:  t = {4'd9, 60'h30812a495};
			8'd38:  t = {4'd9, 60'h52a542402};
			8'd39:  t = {4'd12, 60'h2a5325354348};
			8'd40:  t = {4'd6, 60'h95423b};
			8'd41:  t = {4'd9, 60'h0b208b495};
			8'd42:  t = {4'd9, 60'h05401523b};
			8'd43:  t = {4'd12, 60'h21525828b485};
			8'd44:  t = {4'd9, 60'ha3ba13954};
			8'd45:  t = {4'd12, 60'h4950818a18ba};
			8'd46:  t = {4'd12, 60'h54050b5bab03};
			8'd47:  t = {4'd9, 60'h54858aa8b};
			8'd48:  t = {4'd6, 60'h978579};
			8'd49:  t = {4'd9, 60'h930953573};
			8'd50:  t = {4'd9, 60'h078017157};
			8'd51:  t = {4'd6, 60'h153357};
			8'd52:  t = {4'd9, 60'h978957a12};
			8'd53:  t = {4'd12, 60'ha12950530573};
			8'd54:  t = {4'd12, 60'h802825857a52};
			8'd55:  t = {4'd9, 60'h2a5253357};
			8'd56:  t = {4'd9, 60'h7957893b2};
			8'd57:  t = {4'd12, 60'h95797292027b};
			8'd58:  t = {4'd12, 60'h23b018178157};
			8'd59:  t = {4'd9, 60'hb21b17715};
			8'd60:  t = {4'd12, 60'h958857a13a3b};
			8'd61:  t = {4'd15, 60'h5705097b010aba0};
			8'd62:  t = {4'd15, 60'hba0b03a50807570};
			8'd63:  t = {4'd6, 60'hba57b5};
			8'd64:  t = {4'd3, 60'ha65};
			8'd65:  t = {4'd6, 60'h0835a6};
			8'd66:  t = {4'd6, 60'h9015a6};
			8'd67:  t = {4'd9, 60'h1831985a6};
			8'd68:  t = {4'd6, 60'h165261};
			8'd69:  t = {4'd9, 60'h165126308};
			8'd70:  t = {4'd9, 60'h965906026};
			8'd71:  t = {4'd12, 60'h598582526328};
			8'd72:  t = {4'd6, 60'h23ba65};
			8'd73:  t = {4'd9, 60'hb08b20a65};
			8'd74:  t = {4'd9, 60'h01923b5a6};
			8'd75:  t = {4'd12, 60'h5a61929b298b};
			8'd76:  t = {4'd9, 60'h63b653513};
			8'd77:  t = {4'd12, 60'h08b0b50515b6};
			8'd78:  t = {4'd12, 60'h3b6036065059};
			8'd79:  t = {4'd9, 60'h65969bb98};
			8'd80:  t = {4'd6, 60'h5a6478};
			8'd81:  t = {4'd9, 60'h43047365a};
			8'd82:  t = {4'd9, 60'h1905a6847};
			8'd83:  t = {4'd12, 60'ha65197173794};
			8'd84:  t = {4'd9, 60'h612651478};
			8'd85:  t = {4'd12, 60'h125526304347};
			8'd86:  t = {4'd12, 60'h847905065026};
			8'd87:  t = {4'd15, 60'h739794329596269};
			8'd88:  t = {4'd9, 60'h3b2784a65};
			8'd89:  t = {4'd12, 60'h5a647242027b};
			8'd90:  t = {4'd12, 60'h01947823b5a6};
			8'd91:  t = {4'd15, 60'h9219b294b7b45a6};
			8'd92:  t = {4'd12, 60'h8473b53515b6};
			8'd93:  t = {4'd15, 60'h51b5b610b7b404b};
			8'd94:  t = {4'd15, 60'h059065036b63847};
			8'd95:  t = {4'd12, 60'h65969b4797b9};
			8'd96:  t = {4'd6, 60'ha4964a};
			8'd97:  t = {4'd9, 60'h4a649a083};
			8'd98:  t = {4'd9, 60'ha01a60640};
			8'd99:  t = {4'd12, 60'h83181686461a};
			8'd100: t = {4'd9, 60'h149124264};
			8'd101: t = {4'd12, 60'h308129249264};
			8'd102: t = {4'd6, 60'h024426};
			8'd103: t = {4'd9, 60'h832824426};
			8'd104: t = {4'd9, 60'ha49a64b23};
			8'd105: t = {4'd12, 60'h08228b49a4a6};
			8'd106: t = {4'd12, 60'h3b201606461a};
			8'd107: t = {4'd15, 60'h64161a48121b8b1};
			8'd108: t = {4'd12, 60'h964936913b63};
			8'd109: t = {4'd15, 60'h8b1810b61914641};
			8'd110: t = {4'd9, 60'h3b6360064};
			8'd111: t = {4'd6, 60'h648b68};
			8'd112: t = {4'd9, 60'h7a678a89a};
			8'd113: t = {4'd12, 60'h0730a709a67a};
			8'd114: t = {4'd12, 60'ha671a7178180};
			8'd115: t = {4'd9, 60'ha67a71173};
			8'd116: t = {4'd12, 60'h126168189867};
			8'd117: t = {4'd15, 60'h269291679093739};
			8'd118: t = {4'd9, 60'h780706602};
			8'd119: t = {4'd6, 60'h732672};
			8'd120: t = {4'd12, 60'h23ba68a89867};
			8'd121: t = {4'd15, 60'h20727b09767a9a7};
			8'd122: t = {4'd15, 60'h1801781a767a23b};
			8'd123: t = {4'd12, 60'hb21b17a61671};
			8'd124: t = {4'd15, 60'h896867916b63136};
			8'd125: t = {4'd6, 60'h091b67};
			8'd126: t = {4'd12, 60'h7807063b0b60};
			8'd127: t = {4'd3, 60'h7b6};
			8'd128: t = {4'd3, 60'h76b};
			8'd129: t = {4'd6, 60'h308b76};
			8'd130: t = {4'd6, 60'h019b76};
			8'd131: t = {4'd9, 60'h819831b76};
			8'd132: t = {4'd6, 60'ha126b7};
			8'd133: t = {4'd9, 60'h12a3086b7};
			8'd134: t = {4'd9, 60'h2902a96b7};
			8'd135: t = {4'd12, 60'h6b72a3a83a98};
			8'd136: t = {4'd6, 60'h723627};
			8'd137: t = {4'd9, 60'h708760620};
			8'd138: t = {4'd9, 60'h276237019};
			8'd139: t = {4'd12, 60'h162186198876};
			8'd140: t = {4'd9, 60'ha76a17137};
			8'd141: t = {4'd12, 60'ha7617a187108};
			8'd142: t = {4'd12, 60'h03707a0a96a7};
			8'd143: t = {4'd9, 60'h76a7a88a9};
			8'd144: t = {4'd6, 60'h684b86};
			8'd145: t = {4'd9, 60'h36b306046};
			8'd146: t = {4'd9, 60'h86b846901};
			8'd147: t = {4'd12, 60'h946963931b36};
			8'd148: t = {4'd9, 60'h6846b82a1};
			8'd149: t = {4'd12, 60'h12a30b06b046};
			8'd150: t = {4'd12, 60'h4b846b0292a9};
			8'd151: t = {4'd15, 60'ha93a32943b36463};
			8'd152: t = {4'd9, 60'h823842462};
			8'd153: t = {4'd6, 60'h042462};
			8'd154: t = {4'd12, 60'h190234246438};
			8'd155: t = {4'd9, 60'h194142246};
			8'd156: t = {4'd12, 60'h8138618466a1};
			8'd157: t = {4'd9, 60'ha10a06604};
			8'd158: t = {4'd15, 60'h4634386a3039a93};
			8'd159: t = {4'd6, 60'ha946a4};
			8'd160: t = {4'd6, 60'h49576b};
			8'd161: t = {4'd9, 60'h083495b76};
			8'd162: t = {4'd9, 60'h50154076b};
			8'd163: t = {4'd12, 60'hb76834354315};
			8'd164: t = {4'd9, 60'h954a1276b};
			8'd165: t = {4'd12, 60'h6b712a083495};
			8'd166: t = {4'd12, 60'h76b54a42a402};
			8'd167: t = {4'd15, 60'h348354325a52b76};
			8'd168: t = {4'd9, 60'h723762549};
			8'd169: t = {4'd12, 60'h954086062687};
			8'd170: t = {4'd12, 60'h362376150540};
			8'd171: t = {4'd15, 60'h628687218485158};
			8'd172: t = {4'd12, 60'h954a16176137};
			8'd173: t = {4'd15, 60'h16a176107870954};
			8'd174: t = {4'd15, 60'h40a4a503a6a737a};
			8'd175: t = {4'd12, 60'h76a7a854a48a};
			8'd176: t = {4'd9, 60'h6956b9b89};
			8'd177: t = {4'd12, 60'h36b063056095};
			8'd178: t = {4'd12, 60'h0b805b01556b};
			8'd179: t = {4'd9, 60'h6b3635531};
			8'd180: t = {4'd12, 60'h12a95b9b8b56};
			8'd181: t = {4'd15, 60'h0b306b09656912a};
			8'd182: t = {4'd15, 60'hb85b56805a52025};
			8'd183: t = {4'd12, 60'h6b36352a3a53};
			8'd184: t = {4'd12, 60'h589528562382};
			8'd185: t = {4'd9, 60'h956960062};
			8'd186: t = {4'd15, 60'h158180568382628};
			8'd187: t = {4'd6, 60'h156216};
			8'd188: t = {4'd15, 60'h13616a386569896};
			8'd189: t = {4'd12, 60'ha10a06950560};
			8'd190: t = {4'd6, 60'h03856a};
			8'd191: t = {4'd3, 60'ha56};
			8'd192: t = {4'd6, 60'hb5a75b};
			8'd193: t = {4'd9, 60'hb5ab75830};
			8'd194: t = {4'd9, 60'h5b75ab190};
			8'd195: t = {4'd12, 60'ha75ab7981831};
			8'd196: t = {4'd9, 60'hb12b71751};
			8'd197: t = {4'd12, 60'h08312717572b};
			8'd198: t = {4'd12, 60'h9759279022b7};
			8'd199: t = {4'd15, 60'h75272b592328982};
			8'd200: t = {4'd9, 60'h25a235375};
			8'd201: t = {4'd12, 60'h820852875a25};
			8'd202: t = {4'd12, 60'h9015a35373a2};
			8'd203: t = {4'd15, 60'h982921872a25752};
			8'd204: t = {4'd6, 60'h135375};
			8'd205: t = {4'd9, 60'h087071175};
			8'd206: t = {4'd9, 60'h903935537};
			8'd207: t = {4'd6, 60'h987597};
			8'd208: t = {4'd9, 60'h5845a8ab8};
			8'd209: t = {4'd12, 60'h5045b05abb30};
			8'd210: t = {4'd12, 60'h01984a8aba45};
			8'd211: t = {4'd15, 60'hab4a45b34941314};
			8'd212: t = {4'd12, 60'h2512852b8458};
			8'd213: t = {4'd15, 60'h04b0b345b2b151b};
			8'd214: t = {4'd15, 60'h0250592b5458b85};
			8'd215: t = {4'd6, 60'h9452b3};
			8'd216: t = {4'd12, 60'h25a352345384};
			8'd217: t = {4'd9, 60'h5a2524420};
			8'd218: t = {4'd15, 60'h3a235a385458019};
			8'd219: t = {4'd12, 60'h5a2524192942};
			8'd220: t = {4'd9, 60'h845853351};
			8'd221: t = {4'd6, 60'h045105};
			8'd222: t = {4'd12, 60'h845853905035};
			8'd223: t = {4'd3, 60'h945};
			8'd224: t = {4'd9, 60'h4b749b9ab};
			8'd225: t = {4'd12, 60'h0834979b79ab};
			8'd226: t = {4'd12, 60'h1ab1b414074b};
			8'd227: t = {4'd15, 60'h3143481a474bab4};
			8'd228: t = {4'd12, 60'h4b79b492b912};
			8'd229: t = {4'd15, 60'h9749b791b2b1083};
			8'd230: t = {4'd9, 60'hb74b42240};
			8'd231: t = {4'd12, 60'hb74b42834324};
			8'd232: t = {4'd12, 60'h29a279237749};
			8'd233: t = {4'd15, 60'h9a7974a27870207};
			8'd234: t = {4'd15, 60'h37a3a274a1a040a};
			8'd235: t = {4'd6, 60'h1a2874};
			8'd236: t = {4'd9, 60'h491417713};
			8'd237: t = {4'd12, 60'h491417081871};
			8'd238: t = {4'd6, 60'h403743};
			8'd239: t = {4'd3, 60'h487};
			8'd240: t = {4'd6, 60'h9a8ab8};
			8'd241: t = {4'd9, 60'h30939bb9a};
			8'd242: t = {4'd9, 60'h01a0a88ab};
			8'd243: t = {4'd6, 60'h31ab3a};
			8'd244: t = {4'd9, 60'h12b1b99b8};
			8'd245: t = {4'd12, 60'h30939b1292b9};
			8'd246: t = {4'd6, 60'h02b80b};
			8'd247: t = {4'd3, 60'h32b};
			8'd248: t = {4'd9, 60'h23828aa89};
			8'd249: t = {4'd6, 60'h9a2092};
			8'd250: t = {4'd12, 60'h23828a0181a8};
			8'd251: t = {4'd3, 60'h1a2};
			8'd252: t = {4'd6, 60'h138918};
			8'd253: t = {4'd3, 60'h091};
			8'd254: t = {4'd3, 60'h038};
			8'd255: t = {4'd0, 60'h0};
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== design/mcc_if.sv =====
// request channels for cells in and triangles out
`default_nettype none
interface mcc_cell_if import mcc_pkg::*; ();
	logic      valid;
	logic      ready;
	mcc_cell_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface mcc_tri_if import mcc_pkg::*; ();
	logic     valid;
	logic     ready;
	mcc_tri_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/marching_cubes_cell.sv =====
// marching cubes cell unit: cube index, edge interpolation, triangle output
// one cell at a time; setup computes the cube index, the low and high positions on each axis
// on the shared 32x32 multiplier, and fetches the rom entry. a cut edge is interpolated per axis
// with the one-bit-per-cycle restoring divider (32 steps), unless an end point is taken;
// a reused edge is read from the stored edge points. each triangle waits out any output stall;
// a cell outside the grid is dropped without output.
// reset restores the register defaults and empties the output register.
`default_nettype none
module marching_cubes_cell import mcc_pkg::*; #(
	parameter int GRID_POINTS = GRID_POINTS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	mcc_cell_if.sink                   cell_in,
	mcc_tri_if.source                  tri_out
);

	localparam logic [31:0] NEAR_MAX = 32'(((64'd1 << FRAC_BITS) - 64'd1) / 64'd1000000);
	localparam logic [10:0] CELL_LIM = 11'(GRID_POINTS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CUBE = 4'd1;
	localparam logic [3:0] S_PMUL = 4'd2;
	localparam logic [3:0] S_PADD = 4'd3;
	localparam logic [3:0] S_TRI  = 4'd4;
	localparam logic [3:0] S_VSEL = 4'd5;
	localparam logic [3:0] S_EPV  = 4'd6;
	localparam logic [3:0] S_EPA  = 4'd7;
	localparam logic [3:0] S_EPB  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_DINI = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;
	localparam logic [3:0] S_EMIT = 4'd13;

	logic [3:0] state_q;

	logic signed [31:0] iso_q;
	logic signed [31:0] org_q [3];
	logic [30:0]        stp_q [3];

	logic [9:0]         cell_q [3];
	logic signed [31:0] val_q [8];
	logic signed [31:0] pos_lo_q [3];
	logic signed [31:0] pos_hi_q [3];
	logic signed [31:0] ept_q [12][3];
	logic [11:0]        evld_q;
	logic signed [31:0] vert_q [3][3];

	logic [7:0]  cube_q;
	logic [63:0] ent_q;
	logic [2:0]  ntri_q;
	logic [2:0]  tk_q;
	logic [1:0]  tv_q;
	logic [1:0]  ax_q;
	logic        ph_q;
	logic [3:0]  edge_q;

	logic signed [31:0] v1_q, p1_q, p2_q, byp_q;
	logic signed [33:0] num_q, num2_q, den_q, dp_q;
	logic [31:0] up_q, un_q, ud_q;
	logic        neg_q, bypass_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q, quo_q;
	logic [4:0]  dc_q;

	logic     ov_q;
	mcc_tri_t out_q;

	function automatic logic [31:0] mag34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = v[33] ? -v : v;
		return n[31:0];
	endfunction

	function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
		logic signed [31:0] r;
		if (v[43:31] == {13{v[43]}}) r = v[31:0];
		else r = v[43] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return r;
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33:31] == {3{v[33]}}) r = v[31:0];
		else r = v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return r;
	endfunction

	// edge corners and their positions on the current axis
	logic [2:0] ca, cb, off_a, off_b, vaddr;
	logic signed [31:0] p1_c, p2_c, vrd;
	always_comb begin
		{ca, cb} = edge_ends(edge_q);
		off_a = corner_off(ca);
		off_b = corner_off(cb);
		p1_c = off_a[ax_q] ? pos_hi_q[ax_q] : pos_lo_q[ax_q];
		p2_c = off_b[ax_q] ? pos_hi_q[ax_q] : pos_lo_q[ax_q];
		vaddr = (state_q == S_EPV) ? ca : cb;
		vrd = val_q[vaddr];
	end

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		if (state_q == S_PMUL) begin
			mul_a = {1'b0, stp_q[ax_q]};
			mul_b = {21'd0, 11'({1'b0, cell_q[ax_q]} + 11'(ph_q))};
		end else begin
			mul_a = up_q;
			mul_b = un_q;
		end
		mul_p = mul_a * mul_b;
	end

	// rom entry of the current cube index
	logic [63:0] rom_c;
	logic [2:0]  rom_ntri;
	always_comb begin
		rom_c = tri_rom(cube_q);
		rom_ntri = ntri_of(rom_c[63:60]);
	end

	// vertex edge select
	logic [3:0] vs_j, vs_idx, vs_nib, vs_edge;
	always_comb begin
		unique case (tv_q)
			2'd1:    vs_j = 4'({tk_q, 1'b0}) + 4'(tk_q) + 4'd2;
			2'd2:    vs_j = 4'({tk_q, 1'b0}) + 4'(tk_q) + 4'd1;
			default: vs_j = 4'({tk_q, 1'b0}) + 4'(tk_q);
		endcase
		vs_idx = ent_q[63:60] - 4'd1 - vs_j;
		vs_nib = ent_q[{vs_idx, 2'b00} +: 4];
		vs_edge = (vs_nib > 4'd11) ? 4'd0 : vs_nib;
	end

	// arithmetic of the current state
	logic [7:0]         cube_c;
	logic signed [43:0] psum;
	logic signed [33:0] fsum;
	logic [32:0]        dv_t;
	logic               dv_ge;
	logic [63:0]        dini;
	logic [31:0]        m_num, m_den;
	always_comb begin
		for (int i = 0; i < 8; i++) cube_c[i] = val_q[i] < iso_q;
		psum = 44'(org_q[ax_q]) + 44'($signed({1'b0, prod_q[42:0]}));
		fsum = neg_q ? 34'(p1_q) - 34'($signed({2'b0, quo_q}))
		             : 34'(p1_q) + 34'($signed({2'b0, quo_q}));
		dv_t = {rem_q, quo_q[31]};
		dv_ge = dv_t >= {1'b0, ud_q};
		dini = prod_q + {33'd0, ud_q[31:1]};
		m_num = mag34(num_q);
		m_den = mag34(den_q);
	end

	assign cell_in.ready = (state_q == S_IDLE);
	assign tri_out.valid = ov_q;
	assign tri_out.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			stp_q[0] <= 31'd65536;
			stp_q[1] <= 31'd65536;
			stp_q[2] <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ISO_LEVEL: iso_q <= cfg_data;
				REG_ORIGIN_X:  org_q[0] <= cfg_data;
				REG_ORIGIN_Y:  org_q[1] <= cfg_data;
				REG_ORIGIN_Z:  org_q[2] <= cfg_data;
				REG_STEP_X:    stp_q[0] <= cfg_data[30:0];
				REG_STEP_Y:    stp_q[1] <= cfg_data[30:0];
				REG_STEP_Z:    stp_q[2] <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			evld_q <= '0;
			tk_q <= '0;
			tv_q <= '0;
			ax_q <= '0;
			ph_q <= 1'b0;
			dc_q <= '0;
		end else begin
			if (ov_q && tri_out.ready && state_q != S_EMIT) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cell_in.valid) begin
						cell_q[0] <= cell_in.data.cell_x;
						cell_q[1] <= cell_in.data.cell_y;
						cell_q[2] <= cell_in.data.cell_z;
						val_q[0] <= cell_in.data.corner_value_0;
						val_q[1] <= cell_in.data.corner_value_1;
						val_q[2] <= cell_in.data.corner_value_2;
						val_q[3] <= cell_in.data.corner_value_3;
						val_q[4] <= cell_in.data.corner_value_4;
						val_q[5] <= cell_in.data.corner_value_5;
						val_q[6] <= cell_in.data.corner_value_6;
						val_q[7] <= cell_in.data.corner_value_7;
						if ({1'b0, cell_in.data.cell_x} < CELL_LIM &&
						    {1'b0, cell_in.data.cell_y} < CELL_LIM &&
						    {1'b0, cell_in.data.cell_z} < CELL_LIM) begin
							state_q <= S_CUBE;
						end
					end
				end
				S_CUBE: begin
					cube_q <= cube_c;
					ax_q <= '0;
					ph_q <= 1'b0;
					state_q <= S_PMUL;
				end
				S_PMUL: begin
					prod_q <= mul_p;
					state_q <= S_PADD;
				end
				S_PADD: begin
					if (ph_q) pos_hi_q[ax_q] <= sat44(psum);
					else pos_lo_q[ax_q] <= sat44(psum);
					ph_q <= ~ph_q;
					if (ph_q && ax_q == 2'd2) begin
						state_q <= S_TRI;
					end else begin
						if (ph_q) ax_q <= ax_q + 2'd1;
						state_q <= S_PMUL;
					end
				end
				S_TRI: begin
					ent_q <= rom_c;
					ntri_q <= rom_ntri;
					tk_q <= '0;
					tv_q <= '0;
					evld_q <= '0;
					state_q <= (rom_ntri == 3'd0) ? S_IDLE : S_VSEL;
				end
				S_VSEL: begin
					if (evld_q[vs_edge]) begin
						vert_q[tv_q][0] <= ept_q[vs_edge][0];
						vert_q[tv_q][1] <= ept_q[vs_edge][1];
						vert_q[tv_q][2] <= ept_q[vs_edge][2];
						if (tv_q == 2'd2) begin
							tv_q <= '0;
							state_q <= S_EMIT;
						end else begin
							tv_q <= tv_q + 2'd1;
						end
					end else begin
						edge_q <= vs_edge;
						ax_q <= '0;
						state_q <= S_EPV;
					end
				end
				S_EPV: begin
					v1_q <= vrd;
					state_q <= S_EPA;
				end
				S_EPA: begin
					num_q <= 34'(iso_q) - 34'(v1_q);
					num2_q <= 34'(iso_q) - 34'(vrd);
					den_q <= 34'(vrd) - 34'(v1_q);
					dp_q <= 34'(p2_c) - 34'(p1_c);
					p1_q <= p1_c;
					p2_q <= p2_c;
					state_q <= S_EPB;
				end
				S_EPB: begin
					up_q <= mag34(dp_q);
					un_q <= (m_num > m_den) ? m_den : m_num;
					ud_q <= m_den;
					neg_q <= num_q[33] ^ den_q[33] ^ dp_q[33];
					priority if (m_num <= NEAR_MAX) begin
						bypass_q <= 1'b1;
						byp_q <= p1_q;
						state_q <= S_FIN;
					end else if (mag34(num2_q) <= NEAR_MAX) begin
						bypass_q <= 1'b1;
						byp_q <= p2_q;
						state_q <= S_FIN;
					end else if (m_den <= NEAR_MAX) begin
						bypass_q <= 1'b1;
						byp_q <= p1_q;
						state_q <= S_FIN;
					end else begin
						bypass_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= mul_p;
					state_q <= S_DINI;
				end
				S_DINI: begin
					rem_q <= dini[63:32];
					quo_q <= dini[31:0];
					dc_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= dv_ge ? 32'(dv_t - {1'b0, ud_q}) : dv_t[31:0];
					quo_q <= {quo_q[30:0], dv_ge};
					dc_q <= dc_q + 5'd1;
					if (dc_q == 5'd31) state_q <= S_FIN;
				end
				S_FIN: begin
					ept_q[edge_q][ax_q] <= bypass_q ? byp_q : sat34(fsum);
					if (ax_q == 2'd2) begin
						evld_q[edge_q] <= 1'b1;
						state_q <= S_VSEL;
					end else begin
						ax_q <= ax_q + 2'd1;
						state_q <= S_EPV;
					end
				end
				S_EMIT: begin
					if (!ov_q || tri_out.ready) begin
						ov_q <= 1'b1;
						out_q.first_x <= vert_q[0][0];
						out_q.first_y <= vert_q[0][1];
						out_q.first_z <= vert_q[0][2];
						out_q.second_x <= vert_q[1][0];
						out_q.second_y <= vert_q[1][1];
						out_q.second_z <= vert_q[1][2];
						out_q.third_x <= vert_q[2][0];
						out_q.third_y <= vert_q[2][1];
						out_q.third_z <= vert_q[2][2];
						out_q.last_triangle <= (tk_q == ntri_q - 3'd1);
						if (tk_q == ntri_q - 3'd1) begin
							state_q <= S_IDLE;
						end else begin
							tk_q <= tk_q + 3'd1;
							state_q <= S_VSEL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
